// ===== rtl/sea_pkg.sv =====
package sea_pkg;

  localparam int unsigned MAX_EXTENTS = 64;
  localparam int unsigned STEP_W      = $clog2(MAX_EXTENTS);
  localparam int unsigned CNT_W       = $clog2(MAX_EXTENTS + 1);
  localparam int unsigned PCS_W       = $clog2(MAX_EXTENTS + 2);
  localparam int unsigned SEC_W       = 30;
  localparam int unsigned LEN_W       = 31;
  localparam int unsigned ID_W        = 30;
  localparam int unsigned CUR_W       = 32;

  localparam logic [LEN_W-1:0] SECTOR_LIMIT = 31'h4000_0000;

  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_READ   = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_TABLE_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROTATE,
    CELL_SPREAD,
    CELL_PACK
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     phase;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    WALK_READ,
    WALK_DELETE,
    WALK_CHECK,
    WALK_COMMIT
  } walk_mode_e;

  typedef struct packed {
    logic       init;
    logic       step;
    logic       grow;
    walk_mode_e mode;
  } walk_ctl_t;

  // one extent plus an optional pending extent that sorts just before it
  typedef struct packed {
    logic             valid;
    logic [SEC_W-1:0] start;
    logic [LEN_W-1:0] len;
    logic [ID_W-1:0]  owner;
    logic             pend;
    logic [SEC_W-1:0] pstart;
    logic [LEN_W-1:0] plen;
    logic [ID_W-1:0]  powner;
  } ext_t;

  typedef struct packed {
    logic             found;
    logic [ID_W-1:0]  owner;
    status_e          status;
    logic [CNT_W-1:0] vcount;
  } walk_res_t;

endpackage

// ===== rtl/sea_cell.sv =====
module sea_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sea_pkg::cell_ctl_t ctl_i,
  input  logic              odd_i,
  input  sea_pkg::ext_t     left_i,
  input  sea_pkg::ext_t     right_i,
  output sea_pkg::ext_t     q_o
);

  sea_pkg::ext_t cell_q, cell_d;
  logic left_two, my_two;

  assign left_two = left_i.valid & left_i.pend;
  assign my_two   = cell_q.valid & cell_q.pend;

  always_comb begin
    cell_d = cell_q;
    case (ctl_i.op)
      sea_pkg::CELL_ROTATE: begin
        cell_d = right_i;
      end
      sea_pkg::CELL_SPREAD: begin
        // a cell holding two extents hands its upper one to the right
        if (left_two) begin
          if (my_two) begin
            cell_d.start  = cell_q.pstart;
            cell_d.len    = cell_q.plen;
            cell_d.owner  = cell_q.powner;
            cell_d.pend   = 1'b1;
            cell_d.pstart = left_i.start;
            cell_d.plen   = left_i.len;
            cell_d.powner = left_i.owner;
          end else if (cell_q.valid) begin
            cell_d.pend   = 1'b1;
            cell_d.pstart = left_i.start;
            cell_d.plen   = left_i.len;
            cell_d.powner = left_i.owner;
          end else begin
            cell_d.valid = 1'b1;
            cell_d.start = left_i.start;
            cell_d.len   = left_i.len;
            cell_d.owner = left_i.owner;
            cell_d.pend  = 1'b0;
          end
        end else if (my_two) begin
          cell_d.start = cell_q.pstart;
          cell_d.len   = cell_q.plen;
          cell_d.owner = cell_q.powner;
          cell_d.pend  = 1'b0;
        end
      end
      sea_pkg::CELL_PACK: begin
        // odd-even transposition, valid extents drift toward cell 0
        if (odd_i == ctl_i.phase) begin
          if (!cell_q.valid && right_i.valid) begin
            cell_d = right_i;
          end
        end else begin
          if (!left_i.valid && cell_q.valid) begin
            cell_d.valid = 1'b0;
          end
        end
      end
      default: begin
        cell_d = cell_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;

endmodule

// ===== rtl/sea_walk.sv =====
module sea_walk (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sea_pkg::walk_ctl_t             ctl_i,
  input  sea_pkg::ext_t                  head_i,
  input  logic [sea_pkg::LEN_W-1:0]      total_i,
  input  logic [sea_pkg::LEN_W-1:0]      count_i,
  input  logic [sea_pkg::ID_W-1:0]       fid_i,
  input  logic [sea_pkg::SEC_W-1:0]      addr_i,
  output sea_pkg::ext_t                  head_o,
  output sea_pkg::walk_res_t             res_o
);

  logic [sea_pkg::CUR_W-1:0] cur_q, cur_d;
  logic [sea_pkg::LEN_W-1:0] need_q, need_d;
  logic [sea_pkg::PCS_W-1:0] pieces_q, pieces_d;
  logic [sea_pkg::CNT_W-1:0] vcount_q, vcount_d;
  logic                      done_q, done_d;
  logic                      found_q, found_d;
  logic [sea_pkg::ID_W-1:0]  owner_q, owner_d;

  logic [sea_pkg::CUR_W-1:0] total_x, start_x, end_x, addr_x, gap_end, gap;
  logic [sea_pkg::LEN_W-1:0] take;
  logic [sea_pkg::PCS_W:0]   after_cnt;
  logic                      act;

  assign total_x = {1'b0, total_i};
  assign start_x = {2'b00, head_i.start};
  assign end_x   = start_x + {1'b0, head_i.len};
  assign addr_x  = {2'b00, addr_i};
  assign act     = !done_q && (need_q != '0) && (cur_q < total_x);
  assign gap_end = (head_i.valid && start_x < total_x) ? start_x : total_x;
  assign gap     = gap_end - cur_q;
  assign take    = (gap > {1'b0, need_q}) ? need_q : gap[sea_pkg::LEN_W-1:0];
  assign after_cnt = (sea_pkg::PCS_W + 1)'(vcount_q) + (sea_pkg::PCS_W + 1)'(pieces_q);

  always_comb begin
    cur_d    = cur_q;
    need_d   = need_q;
    pieces_d = pieces_q;
    vcount_d = vcount_q;
    done_d   = done_q;
    found_d  = found_q;
    owner_d  = owner_q;
    head_o   = head_i;
    if (ctl_i.step) begin
      case (ctl_i.mode)
        sea_pkg::WALK_READ: begin
          if (head_i.valid && addr_x >= start_x && addr_x < end_x && !found_q) begin
            found_d = 1'b1;
            owner_d = head_i.owner;
          end
        end
        sea_pkg::WALK_DELETE: begin
          if (head_i.valid && head_i.owner == fid_i) begin
            head_o.valid = 1'b0;
            vcount_d     = vcount_q - 1'b1;
          end
        end
        sea_pkg::WALK_CHECK, sea_pkg::WALK_COMMIT: begin
          if (act) begin
            if (gap_end > cur_q) begin
              need_d   = need_q - take;
              pieces_d = pieces_q + 1'b1;
              if (ctl_i.mode == sea_pkg::WALK_COMMIT) begin
                if (head_i.valid) begin
                  head_o.pend   = 1'b1;
                  head_o.pstart = cur_q[sea_pkg::SEC_W-1:0];
                  head_o.plen   = take;
                  head_o.powner = fid_i;
                end else begin
                  head_o.valid = 1'b1;
                  head_o.start = cur_q[sea_pkg::SEC_W-1:0];
                  head_o.len   = take;
                  head_o.owner = fid_i;
                  head_o.pend  = 1'b0;
                end
              end
            end
            if (head_i.valid) begin
              cur_d = end_x;
            end
          end
          // first free cell ends the sorted run, the final gap is handled there
          if (!act || !head_i.valid) begin
            done_d = 1'b1;
          end
        end
        default: begin
          done_d = done_q;
        end
      endcase
    end
    if (ctl_i.grow) begin
      vcount_d = vcount_q + sea_pkg::CNT_W'(pieces_q);
    end
    if (ctl_i.init) begin
      cur_d    = '0;
      need_d   = count_i;
      pieces_d = '0;
      done_d   = 1'b0;
      found_d  = 1'b0;
      owner_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q    <= '0;
      need_q   <= '0;
      pieces_q <= '0;
      vcount_q <= '0;
      done_q   <= 1'b0;
      found_q  <= 1'b0;
      owner_q  <= '0;
    end else begin
      cur_q    <= cur_d;
      need_q   <= need_d;
      pieces_q <= pieces_d;
      vcount_q <= vcount_d;
      done_q   <= done_d;
      found_q  <= found_d;
      owner_q  <= owner_d;
    end
  end

  always_comb begin
    res_o.found  = found_q;
    res_o.owner  = owner_q;
    res_o.vcount = vcount_q;
    if (need_q != '0) begin
      res_o.status = sea_pkg::ST_NO_SPACE;
    end else if (after_cnt > (sea_pkg::PCS_W + 1)'(sea_pkg::MAX_EXTENTS)) begin
      res_o.status = sea_pkg::ST_TABLE_FULL;
    end else begin
      res_o.status = sea_pkg::ST_OK;
    end
  end

endmodule

// ===== rtl/sector_extent_allocator_unit.sv =====
// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+-----------------------------------------
// request   | in        | start, busy            | req_type_i file_id_i sector_count_i
//           |           |                        | sector_addr_i
// result    | out       | done_o (one cycle)     | found_o owner_id_o status_o
// config    | in        | cfg_we_i               | cfg_wdata_i (total_sectors)
//
// the extent table is a row of 64 cells kept sorted by start sector, used cells first
// read rotates the cell row past the head unit, delete rotates and then packs the row,
// write rotates to check, on commit rotates again and spreads; other codes go to result
// reset clears all cells and sets total_sectors to 2^30, no clearing pass is needed
// busy is high from the accepted item until its result strobe, the result cannot be stalled
module sector_extent_allocator_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  req_type_i,
  input  logic [sea_pkg::ID_W-1:0]    file_id_i,
  input  logic [sea_pkg::LEN_W-1:0]   sector_count_i,
  input  logic [sea_pkg::SEC_W-1:0]   sector_addr_i,
  input  logic                        cfg_we_i,
  input  logic [sea_pkg::LEN_W-1:0]   cfg_wdata_i,
  output logic                        done_o,
  output logic                        found_o,
  output logic [sea_pkg::ID_W-1:0]    owner_id_o,
  output logic [1:0]                  status_o
);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_READ    = 10'b00_0000_0010,
    S_DSCAN   = 10'b00_0000_0100,
    S_DPACK   = 10'b00_0000_1000,
    S_WCHK    = 10'b00_0001_0000,
    S_WTAIL   = 10'b00_0010_0000,
    S_WDEC    = 10'b00_0100_0000,
    S_WCOMMIT = 10'b00_1000_0000,
    S_WSPREAD = 10'b01_0000_0000,
    S_RESULT  = 10'b10_0000_0000
  } state_e;

  state_e                        state_q, state_d;
  logic [sea_pkg::STEP_W-1:0]    step_q, step_d;
  logic [sea_pkg::ID_W-1:0]      fid_q;
  logic [sea_pkg::LEN_W-1:0]     cnt_q;
  logic [sea_pkg::SEC_W-1:0]     addr_q;
  logic [sea_pkg::LEN_W-1:0]     total_q;
  sea_pkg::status_e              status_q, status_d;
  logic                          accept, last_step;

  sea_pkg::cell_ctl_t            cell_ctl;
  sea_pkg::walk_ctl_t            walk_ctl;
  sea_pkg::walk_res_t            walk_res;
  sea_pkg::ext_t                 head_in, head_out, tail_in, edge_left;
  sea_pkg::ext_t                 cells [sea_pkg::MAX_EXTENTS];

  assign accept    = start && !busy;
  assign busy      = (state_q != S_IDLE);
  assign last_step = (step_q == sea_pkg::STEP_W'(sea_pkg::MAX_EXTENTS - 1));

  // total_sectors saturates at the 30-bit sector space
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= sea_pkg::SECTOR_LIMIT;
    end else if (cfg_we_i) begin
      total_q <= (cfg_wdata_i > sea_pkg::SECTOR_LIMIT) ? sea_pkg::SECTOR_LIMIT : cfg_wdata_i;
    end
  end

  // request fields, held for the whole item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fid_q  <= file_id_i;
      cnt_q  <= sector_count_i;
      addr_q <= sector_addr_i;
    end
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    status_d = status_q;
    cell_ctl = '{op: sea_pkg::CELL_HOLD, phase: step_q[0]};
    walk_ctl = '{init: 1'b0, step: 1'b0, grow: 1'b0, mode: sea_pkg::WALK_READ};
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          walk_ctl.init = 1'b1;
          status_d      = sea_pkg::ST_OK;
          step_d        = '0;
          case (sea_pkg::req_e'(req_type_i))
            sea_pkg::REQ_WRITE:  state_d = S_WCHK;
            sea_pkg::REQ_DELETE: state_d = S_DSCAN;
            sea_pkg::REQ_READ:   state_d = S_READ;
            default:             state_d = S_RESULT;
          endcase
        end
      end
      S_READ: begin
        cell_ctl.op   = sea_pkg::CELL_ROTATE;
        walk_ctl.step = 1'b1;
        walk_ctl.mode = sea_pkg::WALK_READ;
        step_d        = step_q + 1'b1;
        if (last_step) begin
          state_d = S_RESULT;
        end
      end
      S_DSCAN: begin
        cell_ctl.op   = sea_pkg::CELL_ROTATE;
        walk_ctl.step = 1'b1;
        walk_ctl.mode = sea_pkg::WALK_DELETE;
        step_d        = step_q + 1'b1;
        if (last_step) begin
          state_d = S_DPACK;
        end
      end
      S_DPACK: begin
        cell_ctl.op = sea_pkg::CELL_PACK;
        step_d      = step_q + 1'b1;
        if (last_step) begin
          state_d = S_RESULT;
        end
      end
      S_WCHK: begin
        cell_ctl.op   = sea_pkg::CELL_ROTATE;
        walk_ctl.step = 1'b1;
        walk_ctl.mode = sea_pkg::WALK_CHECK;
        step_d        = step_q + 1'b1;
        if (last_step) begin
          state_d = S_WTAIL;
        end
      end
      S_WTAIL: begin
        // gap above the last extent when every cell is in use
        walk_ctl.step = 1'b1;
        walk_ctl.mode = sea_pkg::WALK_CHECK;
        state_d       = S_WDEC;
      end
      S_WDEC: begin
        status_d = walk_res.status;
        if (walk_res.status == sea_pkg::ST_OK) begin
          walk_ctl.init = 1'b1;
          walk_ctl.grow = 1'b1;
          step_d        = '0;
          state_d       = S_WCOMMIT;
        end else begin
          state_d = S_RESULT;
        end
      end
      S_WCOMMIT: begin
        cell_ctl.op   = sea_pkg::CELL_ROTATE;
        walk_ctl.step = 1'b1;
        walk_ctl.mode = sea_pkg::WALK_COMMIT;
        step_d        = step_q + 1'b1;
        if (last_step) begin
          state_d = S_WSPREAD;
        end
      end
      S_WSPREAD: begin
        // pending extents ripple right until each cell holds one
        cell_ctl.op = sea_pkg::CELL_SPREAD;
        step_d      = step_q + 1'b1;
        if (last_step) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      step_q   <= '0;
      status_q <= sea_pkg::ST_OK;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      status_q <= status_d;
    end
  end

  // head unit sees cell 0, or an empty cell for the final gap
  assign head_in = (state_q == S_WTAIL) ? '0 : cells[0];

  sea_walk u_walk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (walk_ctl),
    .head_i  (head_in),
    .total_i (total_q),
    .count_i (accept ? sector_count_i : cnt_q),
    .fid_i   (fid_q),
    .addr_i  (addr_q),
    .head_o  (head_out),
    .res_o   (walk_res)
  );

  // the rotated head re-enters at the far end, otherwise nothing comes from there
  assign tail_in = (cell_ctl.op == sea_pkg::CELL_ROTATE) ? head_out : '0;

  // cell 0 has a permanently used neighbor on its left, so nothing moves past it
  always_comb begin
    edge_left       = '0;
    edge_left.valid = 1'b1;
  end

  for (genvar i = 0; i < sea_pkg::MAX_EXTENTS; i++) begin : g_cell
    sea_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (cell_ctl),
      .odd_i   (1'(i % 2)),
      .left_i  ((i == 0) ? edge_left : cells[(i == 0) ? 0 : i - 1]),
      .right_i ((i == sea_pkg::MAX_EXTENTS - 1) ? tail_in :
                cells[(i == sea_pkg::MAX_EXTENTS - 1) ? i : i + 1]),
      .q_o     (cells[i])
    );
  end

  assign done_o     = (state_q == S_RESULT);
  assign found_o    = walk_res.found;
  assign owner_id_o = walk_res.owner;
  assign status_o   = status_q;

  a_strobe_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy)
    else $error("result strobe longer than one cycle");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted item did not raise busy");

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_res.vcount <= sea_pkg::CNT_W'(sea_pkg::MAX_EXTENTS))
    else $error("extent count out of range");

  a_found_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && found_o |-> status_o == sea_pkg::ST_OK)
    else $error("read reported an error status");

  a_commit_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WSPREAD |-> !(cells[sea_pkg::MAX_EXTENTS - 1].valid &&
                               cells[sea_pkg::MAX_EXTENTS - 1].pend))
    else $error("extent pushed past the last cell");

endmodule
